// ===== design/scc_pkg.sv =====
// Package for the sampled curve curvature block: sizes, codes and the
// command and status bundles between the controller and the datapath.
// Has no dependencies; all other design files use it by scoped names.
package scc_pkg;

    // Row storage.
    localparam int MAX_COLUMNS = 64;
    localparam int POS_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = 7;
    localparam int DATA_W      = 32;

    // Shared divider sizes.
    localparam int DIV_NUM_W   = 82;
    localparam int DIV_DEN_W   = 64;
    localparam int DIV_CNT_W   = 7;
    localparam logic [DIV_CNT_W-1:0] SLOPE_ITERS = DIV_CNT_W'(48);
    localparam logic [DIV_CNT_W-1:0] WIDE_ITERS  = DIV_CNT_W'(DIV_NUM_W);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    // Divider operand choice.
    typedef enum logic [1:0] {
        DIV_SLOPE,
        DIV_CURV,
        DIV_NORM
    } t_div_sel;

    // Multiplier operand choice.
    typedef enum logic [1:0] {
        MUL_SPAN,
        MUL_SLOPE,
        MUL_DEN_HI,
        MUL_DEN_LO
    } t_mul_sel;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,
        S_CHECK,
        S_DIVU,
        S_WDIVU,
        S_USAT,
        S_SQ,
        S_SQRT,
        S_WSQRT,
        S_DEN1,
        S_DEN2,
        S_DEN3,
        S_DIV1,
        S_WDIV1,
        S_DIV2,
        S_WDIV2,
        S_FIN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     calc;
        logic     simple;
        logic     div_start;
        t_div_sel div_sel;
        logic     usat;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sqrt_start;
        logic     den_sum;
        logic     fin;
        logic     out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic produce;
        logic pos_zero;
        logic zero_sp;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/scc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on scc_pkg for its operand widths.
module scc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [scc_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [scc_pkg::DIV_DEN_W-1:0] i_den,
    input  logic [scc_pkg::DIV_CNT_W-1:0] i_iters,
    output logic                          o_busy,
    output logic [scc_pkg::DIV_NUM_W-1:0] o_quot
);

    logic [scc_pkg::DIV_NUM_W-1:0] r_q;
    logic [scc_pkg::DIV_DEN_W-1:0] r_rem;
    logic [scc_pkg::DIV_DEN_W-1:0] r_den;
    logic [scc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic [scc_pkg::DIV_DEN_W:0]   rem2;
    logic [scc_pkg::DIV_DEN_W:0]   den_ext;
    logic                          ge;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        rem2    = {r_rem, r_q[scc_pkg::DIV_NUM_W-1]};
        den_ext = {1'b0, r_den};
        ge      = rem2 >= den_ext;
    end

    // Control: busy flag and iteration count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_iters;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == scc_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Numerator shifts out on top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[scc_pkg::DIV_NUM_W-2:0], ge};
            r_rem <= ge ? scc_pkg::DIV_DEN_W'(rem2 - den_ext)
                        : rem2[scc_pkg::DIV_DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

// ===== design/scc_ctrl.sv =====
// Controller state machine that sequences the curvature datapath.
// Depends on scc_pkg for states and the command and status bundles.
module scc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  scc_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output scc_pkg::t_dp_cmd  o_cmd
);

    scc_pkg::t_state r_state;
    scc_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            scc_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = scc_pkg::S_DIFF;
                end
            end
            scc_pkg::S_DIFF: begin
                o_cmd.calc = 1'b1;
                n_state    = scc_pkg::S_CHECK;
            end
            scc_pkg::S_CHECK: begin
                if (!i_stat.produce) begin
                    n_state = scc_pkg::S_IDLE;
                end else if (i_stat.pos_zero || i_stat.zero_sp) begin
                    o_cmd.simple = 1'b1;
                    n_state      = scc_pkg::S_DONE;
                end else begin
                    n_state = scc_pkg::S_DIVU;
                end
            end
            scc_pkg::S_DIVU: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = scc_pkg::DIV_SLOPE;
                n_state         = scc_pkg::S_WDIVU;
            end
            scc_pkg::S_WDIVU: begin
                if (!i_stat.div_busy) begin
                    n_state = scc_pkg::S_USAT;
                end
            end
            scc_pkg::S_USAT: begin
                o_cmd.usat    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = scc_pkg::MUL_SPAN;
                n_state       = scc_pkg::S_SQ;
            end
            scc_pkg::S_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = scc_pkg::MUL_SLOPE;
                n_state       = scc_pkg::S_SQRT;
            end
            scc_pkg::S_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = scc_pkg::S_WSQRT;
            end
            scc_pkg::S_WSQRT: begin
                if (!i_stat.sqrt_busy) begin
                    n_state = scc_pkg::S_DEN1;
                end
            end
            scc_pkg::S_DEN1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = scc_pkg::MUL_DEN_HI;
                n_state       = scc_pkg::S_DEN2;
            end
            scc_pkg::S_DEN2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = scc_pkg::MUL_DEN_LO;
                n_state       = scc_pkg::S_DEN3;
            end
            scc_pkg::S_DEN3: begin
                o_cmd.den_sum = 1'b1;
                n_state       = scc_pkg::S_DIV1;
            end
            scc_pkg::S_DIV1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = scc_pkg::DIV_CURV;
                n_state         = scc_pkg::S_WDIV1;
            end
            scc_pkg::S_WDIV1: begin
                if (!i_stat.div_busy) begin
                    n_state = scc_pkg::S_DIV2;
                end
            end
            scc_pkg::S_DIV2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = scc_pkg::DIV_NORM;
                n_state         = scc_pkg::S_WDIV2;
            end
            scc_pkg::S_WDIV2: begin
                if (!i_stat.div_busy) begin
                    n_state = scc_pkg::S_FIN;
                end
            end
            scc_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = scc_pkg::S_DONE;
            end
            scc_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = scc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/scc_dp.sv =====
// Datapath: row memories, row bookkeeping, differences, multiplier,
// square root, divider and the output register. Uses scc_pkg and scc_div.
module scc_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [scc_pkg::CNT_W-1:0]  i_cfg_wr_data,
    input  logic [scc_pkg::DATA_W-1:0] i_sample,
    input  logic                       i_new_set,
    input  logic                       i_stall,
    input  scc_pkg::t_dp_cmd           i_cmd,
    output scc_pkg::t_dp_stat          o_stat,
    output logic                       o_valid,
    output logic [scc_pkg::DATA_W-1:0] o_result_value,
    output logic                       o_last_of_row,
    output logic [1:0]                 o_status
);

    localparam int PW = scc_pkg::POS_W;
    localparam int CW = scc_pkg::CNT_W;
    localparam int DW = scc_pkg::DATA_W;

    // Row memories for columns other than the abscissa.
    logic [DW-1:0] older_mem [scc_pkg::MAX_COLUMNS];
    logic [DW-1:0] newer_mem [scc_pkg::MAX_COLUMNS];

    logic [CW-1:0] r_col_cnt;
    logic [PW-1:0] r_col_pos;
    logic [1:0]    r_rows_seen;
    logic [DW-1:0] r_cur_x;
    logic [DW-1:0] r_older_x;
    logic [DW-1:0] r_newer_x;

    logic [PW-1:0] r_pos;
    logic          r_last;
    logic          r_produce;
    logic [DW-1:0] r_sample;
    logic [DW-1:0] r_rd_old;
    logic [DW-1:0] r_rd_new;

    logic [CW-1:0] cols_eff;
    logic [PW-1:0] pos_c;
    logic [1:0]    rows_c;
    logic          last_c;

    // Column count clamp and the position of an arriving element.
    always_comb begin
        if (r_col_cnt < CW'(2)) begin
            cols_eff = CW'(2);
        end else if (r_col_cnt > CW'(scc_pkg::MAX_COLUMNS)) begin
            cols_eff = CW'(scc_pkg::MAX_COLUMNS);
        end else begin
            cols_eff = r_col_cnt;
        end
        pos_c  = i_new_set ? '0 : r_col_pos;
        rows_c = i_new_set ? 2'd0 : r_rows_seen;
        last_c = {1'b0, pos_c} >= (cols_eff - 1'b1);
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= CW'(2);
        end else if (i_cfg_wr_en) begin
            r_col_cnt <= i_cfg_wr_data;
        end
    end

    // Row window bookkeeping on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos   <= '0;
            r_rows_seen <= 2'd0;
        end else if (i_cmd.load) begin
            if (last_c) begin
                r_col_pos <= '0;
                if (rows_c != 2'd2) begin
                    r_rows_seen <= rows_c + 1'b1;
                end else begin
                    r_rows_seen <= rows_c;
                end
            end else begin
                r_col_pos   <= pos_c + 1'b1;
                r_rows_seen <= rows_c;
            end
        end
    end

    // Item capture, abscissa registers and the registered memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos     <= pos_c;
            r_last    <= last_c;
            r_produce <= rows_c == 2'd2;
            r_sample  <= i_sample;
            r_rd_old  <= older_mem[pos_c];
            r_rd_new  <= newer_mem[pos_c];
            if (pos_c == '0) begin
                r_cur_x <= i_sample;
            end
        end
        if (i_cmd.calc && r_last) begin
            r_older_x <= r_newer_x;
            r_newer_x <= r_cur_x;
        end
    end

    // Memory write once the old entries have been read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc && (r_pos != '0)) begin
            older_mem[r_pos] <= r_rd_new;
            newer_mem[r_pos] <= r_sample;
        end
    end

    // Differences and their magnitudes.
    logic signed [DW:0]   dx, h1, h0, dy;
    logic signed [DW+2:0] d2;
    logic [DW:0]          dx_m, h1_m, h0_m, dy_m;
    logic [DW+2:0]        d2_m;

    always_comb begin
        dx   = $signed({r_cur_x[DW-1], r_cur_x}) - $signed({r_older_x[DW-1], r_older_x});
        h1   = $signed({r_cur_x[DW-1], r_cur_x}) - $signed({r_newer_x[DW-1], r_newer_x});
        h0   = $signed({r_newer_x[DW-1], r_newer_x}) - $signed({r_older_x[DW-1], r_older_x});
        dy   = $signed({r_sample[DW-1], r_sample}) - $signed({r_rd_old[DW-1], r_rd_old});
        d2   = $signed({{3{r_sample[DW-1]}}, r_sample})
             + $signed({{3{r_rd_old[DW-1]}}, r_rd_old})
             - $signed({{2{r_rd_new[DW-1]}}, r_rd_new, 1'b0});
        dx_m = dx[DW] ? (~dx + 1'b1) : dx;
        h1_m = h1[DW] ? (~h1 + 1'b1) : h1;
        h0_m = h0[DW] ? (~h0 + 1'b1) : h0;
        dy_m = dy[DW] ? (~dy + 1'b1) : dy;
        d2_m = d2[DW+2] ? (~d2 + 1'b1) : d2;
    end

    logic [DW-1:0] r_dx_m, r_h1_m, r_h0_m, r_dy_m;
    logic [DW+1:0] r_d2_m;
    logic          r_neg;
    logic          r_zero_sp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_dx_m    <= dx_m[DW-1:0];
            r_h1_m    <= h1_m[DW-1:0];
            r_h0_m    <= h0_m[DW-1:0];
            r_dy_m    <= dy_m[DW-1:0];
            r_d2_m    <= d2_m[DW+1:0];
            r_neg     <= d2[DW+2];
            r_zero_sp <= (dx == '0) || (h1 == '0) || (h0 == '0);
        end
    end

    // Shared divider.
    logic [scc_pkg::DIV_NUM_W-1:0] div_num;
    logic [scc_pkg::DIV_DEN_W-1:0] div_den;
    logic [scc_pkg::DIV_CNT_W-1:0] div_iters;
    logic                          div_busy;
    logic [scc_pkg::DIV_NUM_W-1:0] div_quot;
    logic [63:0]                   r_span;
    logic [63:0]                   r_den;

    always_comb begin
        case (i_cmd.div_sel)
            scc_pkg::DIV_SLOPE: begin
                div_num   = {r_dy_m, 16'd0, 34'd0};
                div_den   = {32'd0, r_dx_m};
                div_iters = scc_pkg::SLOPE_ITERS;
            end
            scc_pkg::DIV_CURV: begin
                div_num   = {r_d2_m, 48'd0};
                div_den   = r_span;
                div_iters = scc_pkg::WIDE_ITERS;
            end
            default: begin
                div_num   = div_quot;
                div_den   = r_den;
                div_iters = scc_pkg::WIDE_ITERS;
            end
        endcase
    end

    scc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_iters (div_iters),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // Slope magnitude, saturated to 32 bits.
    logic [31:0] r_u;

    always_ff @(posedge i_clk) begin
        if (i_cmd.usat) begin
            r_u <= (div_quot[scc_pkg::DIV_NUM_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                              : div_quot[31:0];
        end
    end

    // Shared 32 by 32 multiplier with its result registered per use.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] r_s;
    logic [63:0] r_phi, r_plo;
    logic [63:0] r_sq_rem, r_sq_res, r_sq_bit;
    logic        r_sq_busy;

    always_comb begin
        case (i_cmd.mul_sel)
            scc_pkg::MUL_SPAN: begin
                mul_a = r_h1_m;
                mul_b = r_h0_m;
            end
            scc_pkg::MUL_SLOPE: begin
                mul_a = r_u;
                mul_b = r_u;
            end
            scc_pkg::MUL_DEN_HI: begin
                mul_a = r_s[63:32];
                mul_b = r_sq_res[31:0];
            end
            default: begin
                mul_a = r_s[31:0];
                mul_b = r_sq_res[31:0];
            end
        endcase
        prod = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                scc_pkg::MUL_SPAN:   r_span <= prod;
                scc_pkg::MUL_SLOPE:  r_s    <= prod + {32'd1, 32'd0};
                scc_pkg::MUL_DEN_HI: r_phi  <= prod;
                default:             r_plo  <= prod;
            endcase
        end
        if (i_cmd.den_sum) begin
            r_den <= r_phi + {32'd0, r_plo[63:32]};
        end
    end

    // Digit-recurrence integer square root, two radicand bits per cycle.
    logic [63:0] sq_trial;
    logic        sq_ge;

    always_comb begin
        sq_trial = r_sq_res + r_sq_bit;
        sq_ge    = r_sq_rem >= sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
        end else if (i_cmd.sqrt_start) begin
            r_sq_busy <= 1'b1;
        end else if (r_sq_busy && (r_sq_bit == 64'd1)) begin
            r_sq_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_sq_rem <= r_s;
            r_sq_res <= '0;
            r_sq_bit <= 64'h4000_0000_0000_0000;
        end else if (r_sq_busy) begin
            if (sq_ge) begin
                r_sq_rem <= r_sq_rem - sq_trial;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    // Final sign, saturation and result selection.
    logic [DW-1:0]                 r_res;
    scc_pkg::t_status              r_stat;
    logic [scc_pkg::DIV_NUM_W-1:0] limit;
    logic                          sat;

    always_comb begin
        limit = r_neg ? scc_pkg::DIV_NUM_W'(33'h0_8000_0000)
                      : scc_pkg::DIV_NUM_W'(33'h0_7FFF_FFFF);
        sat   = div_quot > limit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.simple) begin
            r_res  <= r_pos == '0 ? r_newer_x : '0;
            r_stat <= r_pos == '0 ? scc_pkg::ST_OK : scc_pkg::ST_ZERO;
        end else if (i_cmd.fin) begin
            if (sat) begin
                r_res  <= r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                r_stat <= scc_pkg::ST_SAT;
            end else begin
                r_res  <= r_neg ? (~div_quot[DW-1:0] + 1'b1) : div_quot[DW-1:0];
                r_stat <= scc_pkg::ST_OK;
            end
        end
    end

    // Output register; holds while the receiver stalls.
    logic          r_out_valid;
    logic [DW-1:0] r_out_value;
    logic          r_out_last;
    logic [1:0]    r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= r_res;
            r_out_last   <= r_last;
            r_out_status <= r_stat;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.produce   = r_produce;
        o_stat.pos_zero  = r_pos == '0;
        o_stat.zero_sp   = r_zero_sp;
        o_stat.div_busy  = div_busy;
        o_stat.sqrt_busy = r_sq_busy;
        o_stat.out_free  = !r_out_valid || !i_stall;
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_last_of_row  = r_out_last;
    assign o_status       = r_out_status;

endmodule

// ===== design/sampled_curve_curvature.sv =====
// Top level of the sampled curve curvature block: joins the controller
// and the datapath. Depends on scc_pkg, scc_ctrl and scc_dp.
//
// Input channel: i_valid, i_sample, i_new_set; the block drives o_stall.
// A transfer happens on a rising edge with i_valid high and o_stall low.
// Elements arrive row by row; column 0 of each row is the abscissa.
// i_new_set on an element restarts the row window with that element.
// Output channel: o_valid, o_result_value, o_last_of_row, o_status;
// the receiver drives i_stall. The first two rows of a set give no result.
// One item is worked on at a time. An abscissa column or a zero spacing
// passes from transfer through S_DIFF and S_CHECK to S_DONE, which loads
// the output register; a curvature is paced by the shared bit-serial
// divider (48 slope steps plus two 82-step quotients) and the 32-step
// square root. The next transfer can come in the cycle after the load,
// or after S_DIFF and S_CHECK for a transfer that gives no result.
// A stalled result waits in the output register while the next element
// is taken in; that element finishes only once the register is free.
// Reset clears the row window and sets column_count to 2; the row
// memories are not cleared. i_cfg_wr_en writes column_count; write it
// only while the block is idle.
module sampled_curve_curvature (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [scc_pkg::CNT_W-1:0]         i_cfg_wr_data,
    input  logic                              i_valid,
    input  logic signed [scc_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_new_set,
    output logic                              o_stall,
    output logic                              o_valid,
    output logic signed [scc_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_last_of_row,
    output logic [1:0]                        o_status,
    input  logic                              i_stall
);

    scc_pkg::t_dp_cmd  cmd;
    scc_pkg::t_dp_stat stat;
    logic              ready;

    scc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    scc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample       (i_sample),
        .i_new_set      (i_new_set),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_last_of_row  (o_last_of_row),
        .o_status       (o_status)
    );

    // The block takes an element only when the controller is idle.
    assign o_stall = !ready;

endmodule

// ===== design/scc_checker.sv =====
// Port-level checker for the sampled curve curvature block, with its bind.
// Depends on scc_pkg for the status codes.
module scc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic signed [scc_pkg::DATA_W-1:0] o_result_value,
    input logic                              o_last_of_row,
    input logic [1:0]                        o_status,
    input logic                              i_stall
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value)
                               && $stable(o_status) && $stable(o_last_of_row))
        else $error("stalled result changed");

    // A zero spacing result carries value zero.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == scc_pkg::ST_ZERO |-> o_result_value == '0)
        else $error("zero spacing result not zero");

    // A saturated result sits at one of the two limits.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == scc_pkg::ST_SAT
        |-> o_result_value == 32'sh7FFF_FFFF || o_result_value == 32'sh8000_0000)
        else $error("saturated result not at a limit");

    // No unused status code is ever shown.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("invalid status code");

    // Reset empties the output register.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind sampled_curve_curvature scc_checker u_scc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .o_result_value (o_result_value),
    .o_last_of_row  (o_last_of_row),
    .o_status       (o_status),
    .i_stall        (i_stall)
);

// ===== test/sampled_curve_curvature_tb.sv =====
// Testbench for the sampled curve curvature block: drives rows of Q16.16
// samples through the valid/stall input channel and checks every result.
// Depends on scc_pkg and the sampled_curve_curvature design files.
`timescale 1ns / 100ps

module sampled_curve_curvature_tb;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE       = 400;
    localparam int PHASE_ITEMS  = 140;

    // One element waiting for the driver.
    typedef struct {
        logic [31:0] sample;
        logic        new_set;
    } t_element;

    // One predicted output transfer.
    typedef struct {
        logic [31:0]      value;
        logic             last;
        scc_pkg::t_status st;
    } t_curv_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [scc_pkg::CNT_W-1:0] i_cfg_wr_data = '0;
    logic              i_valid = 1'b0;
    logic signed [31:0] i_sample = '0;
    logic              i_new_set = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic signed [31:0] o_result_value;
    logic              o_last_of_row;
    logic [1:0]        o_status;
    logic              i_stall = 1'b0;

    t_element     pending_elements[$];
    t_curv_result expected_results[$];

    int  errors = 0;
    int  cycles = 0;
    int  send_idle = 8;
    int  recv_idle = 58;
    bit  in_taken = 1'b0;

    // Shadow copy of the row window.
    logic signed [31:0] older_row[scc_pkg::MAX_COLUMNS];
    logic signed [31:0] newer_row[scc_pkg::MAX_COLUMNS];
    logic [scc_pkg::POS_W-1:0] col_pos = '0;
    logic [1:0]         rows_seen = '0;
    logic signed [31:0] row_x = '0;
    logic [scc_pkg::CNT_W-1:0] col_count = scc_pkg::CNT_W'(2);

    sampled_curve_curvature u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .i_sample       (i_sample),
        .i_new_set      (i_new_set),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_last_of_row  (o_last_of_row),
        .o_status       (o_status),
        .i_stall        (i_stall)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic report(input string msg);
        $display("ERROR cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Integer square root, one result bit per pass.
    function automatic logic [63:0] root_floor(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Curvature of the middle point of three samples, in Q16.16.
    function automatic void curvature(input longint x0, input longint x1,
                                      input longint x2, input longint y0,
                                      input longint y1, input longint y2,
                                      output logic [31:0] val,
                                      output scc_pkg::t_status st);
        longint       dx, h1, h0, dy, d2;
        logic [63:0]  slope, sum_sq, root, denom;
        logic [127:0] quot, lim;
        bit           neg;
        dx = x2 - x0;
        h1 = x2 - x1;
        h0 = x1 - x0;
        dy = y2 - y0;
        d2 = y2 + y0 - 2 * y1;
        neg = d2 < 0;
        if (dx == 0 || h1 == 0 || h0 == 0) begin
            val = '0;
            st = scc_pkg::ST_ZERO;
            return;
        end
        slope = (magnitude(dy) << 16) / magnitude(dx);
        if (slope > 64'hFFFF_FFFF) slope = 64'hFFFF_FFFF;
        sum_sq = slope * slope + 64'h1_0000_0000;
        root = root_floor(sum_sq);
        denom = (sum_sq >> 32) * root + (((sum_sq & 64'hFFFF_FFFF) * root) >> 32);
        quot = (128'(magnitude(d2)) << 48) / 128'(magnitude(h1) * magnitude(h0));
        quot = quot / 128'(denom);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quot > lim) begin
            val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            st = scc_pkg::ST_SAT;
        end else begin
            val = neg ? -quot[31:0] : quot[31:0];
            st = scc_pkg::ST_OK;
        end
    endfunction

    // Advances the row window by one element and queues its result if any.
    function automatic void advance_window(input logic [31:0] sample, input logic new_set);
        int           cols;
        int           pos;
        bit           last;
        t_curv_result res;
        cols = col_count;
        if (cols < 2) cols = 2;
        if (cols > scc_pkg::MAX_COLUMNS) cols = scc_pkg::MAX_COLUMNS;
        if (new_set) begin
            col_pos = '0;
            rows_seen = '0;
        end
        pos = col_pos;
        last = pos >= cols - 1;
        if (pos == 0) row_x = sample;
        if (rows_seen >= 2) begin
            res.last = last;
            if (pos == 0) begin
                res.value = newer_row[0];
                res.st = scc_pkg::ST_OK;
            end else begin
                curvature(older_row[0], newer_row[0], row_x, older_row[pos],
                          newer_row[pos], $signed(sample), res.value, res.st);
            end
            expected_results.push_back(res);
        end
        if (pos != 0) begin
            older_row[pos] = newer_row[pos];
            newer_row[pos] = sample;
        end
        if (last) begin
            older_row[0] = newer_row[0];
            newer_row[0] = row_x;
            if (rows_seen < 2) rows_seen++;
            col_pos = '0;
        end else begin
            col_pos = scc_pkg::POS_W'(pos + 1);
        end
    endfunction

    // Checks output transfers, then follows input transfers.
    always @(posedge i_clk) begin
        t_curv_result want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result %h", o_result_value));
            end else begin
                want = expected_results.pop_front();
                if (o_result_value !== want.value)
                    report($sformatf("value %h, want %h", o_result_value, want.value));
                if (o_last_of_row !== want.last)
                    report($sformatf("last_of_row %b, want %b", o_last_of_row, want.last));
                if (o_status !== want.st)
                    report($sformatf("status %0d, want %0d", o_status, want.st));
            end
        end
        if (i_rst_n && i_cfg_wr_en) col_count = i_cfg_wr_data;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) advance_window(i_sample, i_new_set);
    end

    // Sender: presents the next element once the previous one transferred.
    always @(negedge i_clk) begin
        t_element e;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle) begin
                e = pending_elements.pop_front();
                i_valid <= 1'b1;
                i_sample <= e.sample;
                i_new_set <= e.new_set;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random.
    always @(negedge i_clk) begin
        i_stall <= $urandom_range(99) < recv_idle;
    end

    task automatic push_element(input logic [31:0] sample, input logic new_set);
        t_element e;
        e.sample = sample;
        e.new_set = new_set;
        pending_elements.push_back(e);
    endtask

    // Waits until every element transferred and every result arrived.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_elements.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_column_count(input logic [scc_pkg::CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random data sets for one column count; mostly smooth curves.
    task automatic fill_sets(input int requested);
        int          cols, rows, kind, queued;
        bit          paused;
        logic [31:0] x, y;
        cols = requested < 2 ? 2 : (requested > scc_pkg::MAX_COLUMNS ? scc_pkg::MAX_COLUMNS
                                                                      : requested);
        queued = 0;
        paused = 0;
        while (queued < PHASE_ITEMS) begin
            rows = cols >= 32 ? 3 : $urandom_range(3, 8);
            kind = $urandom_range(9);
            x = $urandom;
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    if (c == 0) begin
                        if (kind <= 5) x = x + $urandom_range(1, 1 << 18);
                        else if (kind <= 7) x = $urandom;
                        else x = x + ($urandom_range(1) << 16);
                        y = x;
                    end else if (kind <= 5) begin
                        y = $urandom_range(0, 1 << 21) - (1 << 20);
                    end else if (kind <= 7) begin
                        y = $urandom;
                    end else begin
                        y = $urandom_range(0, 3) << 16;
                    end
                    push_element(y, (r == 0 && c == 0) || $urandom_range(149) == 0);
                    queued++;
                end
            end
            // Sender holds off once until the block is empty.
            if (!paused && queued >= PHASE_ITEMS / 2) begin
                paused = 1;
                drain();
            end
        end
    endtask

    initial begin
        int counts[9] = '{3, 0, 64, 127, 5, 1, 4, 2, 9};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: two columns, extremes, zero spacing, saturation, restarts.
        push_element(32'h0000_0000, 1'b1);
        push_element(32'h0000_0000, 1'b0);
        push_element(32'h0001_0000, 1'b0);
        push_element(32'h0001_0000, 1'b0);
        push_element(32'h0002_0000, 1'b0);
        push_element(32'h0000_0000, 1'b0);
        push_element(32'h0002_0000, 1'b0);
        push_element(32'h0005_0000, 1'b0);
        push_element(32'h0003_0000, 1'b0);
        push_element(32'h7FFF_FFFF, 1'b0);
        push_element(32'h0003_0001, 1'b0);
        push_element(32'h8000_0000, 1'b0);
        push_element(32'h8000_0000, 1'b0);
        push_element(32'h0000_0001, 1'b0);
        push_element(32'h7FFF_FFFF, 1'b0);
        push_element(32'hFFFF_FFFF, 1'b0);
        push_element(32'h0001_0000, 1'b1);
        push_element(32'h1234_5678, 1'b1);
        push_element(32'h0002_0000, 1'b0);
        push_element(32'hFFFF_0000, 1'b0);
        push_element(32'h0004_0000, 1'b0);
        push_element(32'h0001_0000, 1'b0);
        push_element(32'h0008_0000, 1'b0);
        push_element(32'h0003_0000, 1'b0);

        for (int m = 0; m < 3; m++) begin
            send_idle = m == 0 ? 8 : (m == 1 ? 58 : 0);
            recv_idle = m == 0 ? 58 : (m == 1 ? 8 : 0);
            for (int k = 0; k < 3; k++) begin
                drain();
                write_column_count(scc_pkg::CNT_W'(counts[m * 3 + k]));
                fill_sets(counts[m * 3 + k]);
            end
        end
        drain();

        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
